// ----- hw/rtl/ufp_pkg.sv -----
package ufp_pkg;

    localparam logic [7:0] LEAD_E2   = 8'hE2;
    localparam logic [7:0] SECOND_80 = 8'h80;
    localparam logic [7:0] EN_DASH   = 8'h93;
    localparam logic [7:0] EM_DASH   = 8'h94;
    localparam logic [7:0] LSQUO     = 8'h98;
    localparam logic [7:0] RSQUO     = 8'h99;
    localparam logic [7:0] LDQUO     = 8'h9C;
    localparam logic [7:0] RDQUO     = 8'h9D;
    localparam logic [7:0] ELLIPSIS  = 8'hA6;
    localparam logic [7:0] CONT_MASK = 8'hC0;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_DASH  = 7'h2D;
    localparam logic [6:0] CHAR_APOS  = 7'h27;
    localparam logic [6:0] CHAR_QUOTE = 7'h22;
    localparam logic [6:0] CHAR_DOT   = 7'h2E;
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    // one queue entry: up to three copies of a character, then an optional terminator
    typedef struct packed {
        logic [6:0] ch;
        logic [1:0] count;
        logic       term;
    } cmd_t;

endpackage

// ----- hw/rtl/ufp_front.sv -----
module ufp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          full,
    input  logic [7:0]    text_byte,
    input  logic          text_last,
    output logic          cmd_push,
    output ufp_pkg::cmd_t cmd
);
    import ufp_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_AFTER1 = 4'b0010,
        MODE_AFTER2 = 4'b0100,
        MODE_SKIP   = 4'b1000
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  prev_space_reg, prev_space_next;
    logic  emitted_reg, emitted_next;

    logic  accept;
    logic  is_cont;
    logic  is_ws;
    logic  do_fresh;

    assign accept  = push && !full;
    assign is_cont = (text_byte & CONT_MASK) == SECOND_80;
    assign is_ws   = (text_byte == 8'h20) || (text_byte >= 8'h09 && text_byte <= 8'h0D);

    always_comb
    begin
        mode_next       = mode_reg;
        prev_space_next = prev_space_reg;
        emitted_next    = emitted_reg;
        cmd.ch          = CHAR_NONE;
        cmd.count       = 2'd0;
        cmd.term        = text_last;
        do_fresh        = 1'b0;

        case (mode_reg)
            MODE_AFTER1:
            begin
                if (text_byte == SECOND_80)
                    mode_next = MODE_AFTER2;
                else if (is_cont)
                    mode_next = MODE_SKIP;
                else
                    do_fresh = 1'b1;
            end
            MODE_AFTER2:
            begin
                mode_next = MODE_NORMAL;
                case (text_byte)
                    EN_DASH, EM_DASH:
                    begin
                        cmd.ch    = CHAR_DASH;
                        cmd.count = 2'd1;
                    end
                    LSQUO, RSQUO:
                    begin
                        cmd.ch    = CHAR_APOS;
                        cmd.count = 2'd1;
                    end
                    LDQUO, RDQUO:
                    begin
                        cmd.ch    = CHAR_QUOTE;
                        cmd.count = 2'd1;
                    end
                    ELLIPSIS:
                    begin
                        cmd.ch    = CHAR_DOT;
                        cmd.count = 2'd3;
                    end
                    default:
                    begin
                        cmd.count = 2'd0;
                    end
                endcase
                if (cmd.count != 2'd0)
                begin
                    prev_space_next = 1'b0;
                    emitted_next    = 1'b1;
                end
            end
            MODE_SKIP:
            begin
                if (!is_cont)
                    do_fresh = 1'b1;
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            if (text_byte[7])
            begin
                mode_next = (text_byte == LEAD_E2) ? MODE_AFTER1 : MODE_SKIP;
            end
            else
            begin
                mode_next = MODE_NORMAL;
                if (is_ws)
                begin
                    if (!prev_space_reg && emitted_reg)
                    begin
                        cmd.ch    = CHAR_SPACE;
                        cmd.count = 2'd1;
                    end
                    prev_space_next = 1'b1;
                end
                else
                begin
                    cmd.ch          = text_byte[6:0];
                    cmd.count       = 2'd1;
                    prev_space_next = 1'b0;
                    emitted_next    = 1'b1;
                end
            end
        end

        // end of text returns the decoder to its start state
        if (text_last)
        begin
            mode_next       = MODE_NORMAL;
            prev_space_next = 1'b0;
            emitted_next    = 1'b0;
        end
    end

    assign cmd_push = accept && ((cmd.count != 2'd0) || cmd.term);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            prev_space_reg <= 1'b0;
            emitted_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            prev_space_reg <= prev_space_next;
            emitted_reg    <= emitted_next;
        end
    end

endmodule

// ----- hw/rtl/ufp_queue.sv -----
module ufp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ufp_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output ufp_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);
    import ufp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hw/rtl/ufp_back.sv -----
module ufp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ufp_pkg::cmd_t head,
    input  logic          head_empty,
    output logic          head_pop,
    input  logic          pop,
    output logic          empty,
    output logic [6:0]    char_out,
    output logic          char_valid,
    output logic          run_last,
    output logic          text_end
);
    import ufp_pkg::*;

    logic [1:0] sent_reg, sent_next;
    logic       in_chars;
    logic       entry_done;
    logic       take;

    assign in_chars   = sent_reg < head.count;
    assign entry_done = in_chars ? ((sent_reg == head.count - 2'd1) && !head.term) : 1'b1;
    assign take       = pop && !head_empty;

    assign empty      = head_empty;
    assign char_out   = in_chars ? head.ch : CHAR_NONE;
    assign char_valid = in_chars;
    assign text_end   = !in_chars;
    assign run_last   = entry_done;
    assign head_pop   = take && entry_done;

    always_comb
    begin
        sent_next = sent_reg;
        if (take)
            sent_next = entry_done ? 2'd0 : sent_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sent_reg <= 2'd0;
        else
            sent_reg <= sent_next;
    end

endmodule

// ----- hw/rtl/utf8_punctuation_to_ascii_filter_core.sv -----
// channel   direction  handshake        payload
// input     in         push / full      text_byte[7:0], text_last
// result    out        empty / pop      char_out[6:0], char_valid, run_last, text_end
//
// one byte accepted per cycle while the command queue has room
// each character or terminator is its own beat at the result side, taken by one pop,
// so an ellipsis gives three dot beats and a terminator adds one more
// full rises when DEPTH commands are waiting, from result stalls or multi-beat entries
// rst_n clears decoder state and the queue asynchronously
module utf8_punctuation_to_ascii_filter_core #(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       text_last,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] char_out,
    output logic       char_valid,
    output logic       run_last,
    output logic       text_end
);
    import ufp_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic head_empty;
    logic head_pop;

    ufp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .text_byte (text_byte),
        .text_last (text_last),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    ufp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .rd_en   (head_pop),
        .rd_data (head_cmd),
        .full    (full),
        .empty   (head_empty)
    );

    ufp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .char_out   (char_out),
        .char_valid (char_valid),
        .run_last   (run_last),
        .text_end   (text_end)
    );

endmodule

// ----- verif/tb_utf8_punctuation_to_ascii_filter_core.sv -----
`timescale 1ns / 100ps

import ufp_pkg::*;

typedef struct packed {
    logic [6:0] ch;
    logic       valid;
    logic       rl;
    logic       te;
} char_beat_t;

class ascii_filter_model;

    typedef enum logic [1:0] {
        DM_NORMAL,
        DM_AFTER_E2,
        DM_AFTER_E280,
        DM_SKIP
    } decode_mode_t;

    decode_mode_t mode;
    bit           prev_space;
    bit           seen_char;
    char_beat_t   expected_chars[$];
    int           mismatches;

    function new();
        clear_text();
        mismatches = 0;
    endfunction

    function void clear_text();
        mode       = DM_NORMAL;
        prev_space = 1'b0;
        seen_char  = 1'b0;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    function void emit(logic [6:0] ch, logic valid, logic te);
        char_beat_t beat;
        beat.ch    = ch;
        beat.valid = valid;
        beat.rl    = 1'b0;
        beat.te    = te;
        expected_chars.push_back(beat);
    endfunction

    function bit is_blank(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function bit is_cont(logic [7:0] b);
        return (b & CONT_MASK) == SECOND_80;
    endfunction

    function void take_fresh(logic [7:0] b);
        if (b[7])
        begin
            mode = (b == LEAD_E2) ? DM_AFTER_E2 : DM_SKIP;
        end
        else
        begin
            mode = DM_NORMAL;
            if (is_blank(b))
            begin
                if (!prev_space && seen_char)
                    emit(CHAR_SPACE, 1'b1, 1'b0);
                prev_space = 1'b1;
            end
            else
            begin
                emit(b[6:0], 1'b1, 1'b0);
                prev_space = 1'b0;
                seen_char  = 1'b1;
            end
        end
    endfunction

    function void take_third(logic [7:0] b);
        logic [6:0] ch;
        int         n;
        ch = CHAR_NONE;
        n  = 0;
        case (b)
            EN_DASH, EM_DASH: begin ch = CHAR_DASH;  n = 1; end
            LSQUO, RSQUO:     begin ch = CHAR_APOS;  n = 1; end
            LDQUO, RDQUO:     begin ch = CHAR_QUOTE; n = 1; end
            ELLIPSIS:         begin ch = CHAR_DOT;   n = 3; end
            default:          n = 0;
        endcase
        for (int i = 0; i < n; i++)
            emit(ch, 1'b1, 1'b0);
        if (n != 0)
        begin
            prev_space = 1'b0;
            seen_char  = 1'b1;
        end
        mode = DM_NORMAL;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        int n0;
        n0 = expected_chars.size();
        case (mode)
            DM_AFTER_E2:
            begin
                if (b == SECOND_80)
                    mode = DM_AFTER_E280;
                else if (is_cont(b))
                    mode = DM_SKIP;
                else
                    take_fresh(b);
            end
            DM_AFTER_E280: take_third(b);
            DM_SKIP:
            begin
                if (!is_cont(b))
                    take_fresh(b);
            end
            default: take_fresh(b);
        endcase
        if (last)
        begin
            emit(CHAR_NONE, 1'b0, 1'b1);
            clear_text();
        end
        if (expected_chars.size() > n0)
            expected_chars[expected_chars.size() - 1].rl = 1'b1;
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function void check_char(logic [6:0] ch, logic valid, logic rl, logic te);
        char_beat_t exp_beat;
        if (expected_chars.size() == 0)
        begin
            report($sformatf("unexpected beat: ch=%02h valid=%0b run_last=%0b text_end=%0b",
                             ch, valid, rl, te));
        end
        else
        begin
            exp_beat = expected_chars.pop_front();
            if (exp_beat.ch !== ch || exp_beat.valid !== valid ||
                exp_beat.rl !== rl || exp_beat.te !== te)
                report($sformatf({"mismatch: exp ch=%02h valid=%0b run_last=%0b text_end=%0b",
                                  " got ch=%02h valid=%0b run_last=%0b text_end=%0b"},
                                 exp_beat.ch, exp_beat.valid, exp_beat.rl, exp_beat.te,
                                 ch, valid, rl, te));
        end
    endfunction

endclass

module tb_utf8_punctuation_to_ascii_filter_core;

    localparam int RANDOM_BYTES = 270;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] text_byte = 8'h00;
    logic       text_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] char_out;
    logic       char_valid;
    logic       run_last;
    logic       text_end;

    ascii_filter_model model;
    logic [7:0]        text_q[$];
    int                bytes_sent = 0;
    int                prod_calm = 0;
    int                cons_calm = 0;
    int                idle_cycles = 0;

    utf8_punctuation_to_ascii_filter_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .text_last  (text_last),
        .empty      (empty),
        .pop        (pop),
        .char_out   (char_out),
        .char_valid (char_valid),
        .run_last   (run_last),
        .text_end   (text_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // a calm stretch forces zero waits for a while
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, 13);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait(prod_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        text_last <= last;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    function automatic logic [7:0] random_cont();
        return SECOND_80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] random_third();
        case ($urandom_range(0, 8))
            0: return EN_DASH;
            1: return EM_DASH;
            2: return LSQUO;
            3: return RSQUO;
            4: return LDQUO;
            5: return RDQUO;
            6: return ELLIPSIS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_piece();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        else if (sel < 55)
        begin
            n = $urandom_range(9, 14);
            text_q.push_back(n == 14 ? 8'h20 : 8'(n));
        end
        else if (sel < 80)
        begin
            text_q.push_back(LEAD_E2);
            text_q.push_back(SECOND_80);
            text_q.push_back(random_third());
        end
        else if (sel < 88)
        begin
            // lead byte in C0..FF, E2 included, with a random number of continuation bytes
            text_q.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                text_q.push_back(random_cont());
        end
        else if (sel < 93)
            text_q.push_back(random_cont());
        else if (sel < 97)
        begin
            text_q.push_back(LEAD_E2);
            text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
            text_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_random_text();
        int len;
        len = $urandom_range(1, 24);
        text_q.delete();
        while (text_q.size() < len)
            add_piece();
        // sometimes drop the last byte, which can cut a sequence short at the end of the text
        if (text_q.size() > 1 && $urandom_range(0, 3) == 0)
            void'(text_q.pop_back());
        send_text();
    endtask

    task automatic run_directed();
        text_q = '{8'h20, 8'h09, 8'h41, 8'h0D, 8'h0A,
                   LEAD_E2, SECOND_80, EM_DASH,
                   LEAD_E2, SECOND_80, ELLIPSIS,
                   8'h00,
                   LEAD_E2, SECOND_80, 8'h7F,
                   LEAD_E2, 8'h41,
                   LEAD_E2, 8'h85, 8'hBF,
                   8'h0C, 8'h80, 8'hFF, 8'h7A,
                   LEAD_E2};
        send_text();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                model.note_byte(text_byte, text_last);
            if (pop && !empty)
                model.check_char(char_out, char_valid, run_last, text_end);
        end
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            w = draw_wait(cons_calm);
            if (w > 0)
            begin
                pop <= 1'b0;
                repeat (w) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        model = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
            send_random_text();
        push <= 1'b0;
        do @(posedge clk); while (model.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.mismatches == 0 && model.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ufp_pkg.sv
hw/rtl/ufp_front.sv
hw/rtl/ufp_queue.sv
hw/rtl/ufp_back.sv
hw/rtl/utf8_punctuation_to_ascii_filter_core.sv
verif/tb_utf8_punctuation_to_ascii_filter_core.sv
